/* rtl/swrq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sleep/wakeup ready queue package
// Shared widths, default sizes, opcodes and controller/datapath bundles.
// ----------------------------------------------------------------------------
package swrq_pkg;

  localparam int SLEEP_SLOTS_DEF = 16;
  localparam int READY_DEPTH_DEF = 32;
  localparam int ID_BITS         = 8;
  localparam int TICK_BITS       = 16;
  localparam int COUNT_BITS      = 5;

  localparam logic [COUNT_BITS-1:0] WOKE_MAX = '1;

  typedef logic [ID_BITS-1:0]    swrq_id_t;
  typedef logic [TICK_BITS-1:0]  swrq_tick_t;
  typedef logic [COUNT_BITS-1:0] swrq_count_t;

  typedef enum logic [1:0] {
    OP_SLEEP = 2'd0,
    OP_TICK  = 2'd1,
    OP_READY = 2'd2,
    OP_PICK  = 2'd3
  } swrq_op_t;

  // One sleeper entry: the id and the absolute tick at which it wakes.
  typedef struct packed {
    swrq_id_t   id;
    swrq_tick_t deadline;
  } swrq_sleeper_t;

  // Controller to datapath strobes, one per step of work.
  typedef struct packed {
    logic load;
    logic ins_init;
    logic ins_shift;
    logic ins_place;
    logic tick_init;
    logic wake_step;
    logic push;
    logic pop;
    logic pop_rd;
    logic out_load;
  } swrq_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic sl_full;
    logic sl_empty;
    logic shift_gt;
    logic at_head;
    logic wake_now;
  } swrq_stat_t;

endpackage

/* rtl/swrq_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sleep/wakeup ready queue channels
// Valid/ready interfaces for the request channel and the result channel.
// ----------------------------------------------------------------------------
interface swrq_in_if import swrq_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  swrq_id_t   thread_id;
  swrq_tick_t sleep_ticks;

  modport source (output valid, output opcode, output thread_id, output sleep_ticks,
                  input ready);
  modport sink   (input valid, input opcode, input thread_id, input sleep_ticks,
                  output ready);
endinterface

interface swrq_out_if import swrq_pkg::*; ();
  logic        valid;
  logic        ready;
  swrq_id_t    picked_thread;
  logic        picked_valid;
  logic        woke_any;
  swrq_count_t woke_count;
  logic        overflow;

  modport source (output valid, output picked_thread, output picked_valid,
                  output woke_any, output woke_count, output overflow, input ready);
  modport sink   (input valid, input picked_thread, input picked_valid,
                  input woke_any, input woke_count, input overflow, output ready);
endinterface

/* rtl/swrq_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sleep/wakeup ready queue datapath
// Sleeper ring memory, ready FIFO memory, pointers and result registers.
// ----------------------------------------------------------------------------
module swrq_datapath import swrq_pkg::*; #(
  parameter int SLEEP_SLOTS = SLEEP_SLOTS_DEF,
  parameter int READY_DEPTH = READY_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  swrq_cmd_t   cmd,
  output swrq_stat_t  stat,
  input  swrq_id_t    in_id,
  input  swrq_tick_t  in_ticks,
  output swrq_id_t    out_picked_thread,
  output logic        out_picked_valid,
  output logic        out_woke_any,
  output swrq_count_t out_woke_count,
  output logic        out_overflow
);

  localparam int SW  = $clog2(SLEEP_SLOTS);
  localparam int SCW = $clog2(SLEEP_SLOTS + 1);
  localparam int RW  = $clog2(READY_DEPTH);
  localparam int RCW = $clog2(READY_DEPTH + 1);

  localparam logic [SW-1:0]  S_LAST = SW'(SLEEP_SLOTS - 1);
  localparam logic [SCW-1:0] S_FULL = SCW'(SLEEP_SLOTS);
  localparam logic [SCW:0]   S_WRAP = (SCW + 1)'(SLEEP_SLOTS);
  localparam logic [RW-1:0]  R_LAST = RW'(READY_DEPTH - 1);
  localparam logic [RCW-1:0] R_FULL = RCW'(READY_DEPTH);

  function automatic logic [SW-1:0] s_next(input logic [SW-1:0] p);
    return (p == S_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [SW-1:0] s_prev(input logic [SW-1:0] p);
    return (p == '0) ? S_LAST : p - 1'b1;
  endfunction

  function automatic logic [RW-1:0] r_next(input logic [RW-1:0] p);
    return (p == R_LAST) ? '0 : p + 1'b1;
  endfunction

  // Storage
  swrq_sleeper_t sl_mem [SLEEP_SLOTS];
  swrq_id_t      rq_mem [READY_DEPTH];
  swrq_sleeper_t sl_rdata_r;
  swrq_id_t      rq_rdata_r;

  // Control state
  logic [SW-1:0]  s_head_r,  s_head_nxt;
  logic [SCW-1:0] s_count_r, s_count_nxt;
  logic [SW-1:0]  wr_ptr_r,  wr_ptr_nxt;
  swrq_tick_t     now_r,     now_nxt;
  logic [RW-1:0]  r_head_r,  r_head_nxt;
  logic [RW-1:0]  r_tail_r,  r_tail_nxt;
  logic [RCW-1:0] r_count_r, r_count_nxt;

  // Item and result registers
  swrq_id_t    id_r,      id_nxt;
  swrq_tick_t  ticks_r,   ticks_nxt;
  swrq_id_t    picked_r,  picked_nxt;
  logic        pvalid_r,  pvalid_nxt;
  swrq_count_t wcnt_r,    wcnt_nxt;
  logic        ovf_r,     ovf_nxt;

  swrq_id_t    out_picked_r;
  logic        out_pvalid_r;
  logic        out_wany_r;
  swrq_count_t out_wcnt_r;
  logic        out_ovf_r;

  // Memory port signals
  logic          sl_we;
  logic [SW-1:0] sl_waddr;
  swrq_sleeper_t sl_wdata;
  logic [SW-1:0] sl_raddr;
  logic          rq_we;
  logic [RW-1:0] rq_waddr;
  swrq_id_t      rq_wdata;

  logic [SCW:0]  tail_sum;
  logic [SW-1:0] s_tail;
  swrq_tick_t    sl_rem;
  swrq_sleeper_t new_entry;

  assign tail_sum  = (SCW + 1)'(s_head_r) + (SCW + 1)'(s_count_r);
  assign s_tail    = (tail_sum >= S_WRAP) ? SW'(tail_sum - S_WRAP) : SW'(tail_sum);
  assign sl_rem    = sl_rdata_r.deadline - now_r;
  assign new_entry = '{id: id_r, deadline: now_r + ticks_r};

  assign stat.sl_full  = (s_count_r == S_FULL);
  assign stat.sl_empty = (s_count_r == '0);
  assign stat.shift_gt = (sl_rem > ticks_r);
  assign stat.at_head  = (s_prev(wr_ptr_r) == s_head_r);
  assign stat.wake_now = (s_count_r != '0) && (sl_rem == '0);

  always_comb begin
    s_head_nxt  = s_head_r;
    s_count_nxt = s_count_r;
    wr_ptr_nxt  = wr_ptr_r;
    now_nxt     = now_r;
    r_head_nxt  = r_head_r;
    r_tail_nxt  = r_tail_r;
    r_count_nxt = r_count_r;
    id_nxt      = id_r;
    ticks_nxt   = ticks_r;
    picked_nxt  = picked_r;
    pvalid_nxt  = pvalid_r;
    wcnt_nxt    = wcnt_r;
    ovf_nxt     = ovf_r;
    sl_we       = 1'b0;
    sl_waddr    = wr_ptr_r;
    sl_wdata    = new_entry;
    rq_we       = 1'b0;
    rq_waddr    = r_tail_r;
    rq_wdata    = id_r;

    if (cmd.load) begin
      id_nxt     = in_id;
      // A zero-tick sleep wakes on the next tick.
      ticks_nxt  = (in_ticks == '0) ? swrq_tick_t'(1) : in_ticks;
      picked_nxt = '0;
      pvalid_nxt = 1'b0;
      wcnt_nxt   = '0;
      ovf_nxt    = 1'b0;
    end

    if (cmd.ins_init) begin
      if (stat.sl_full) begin
        ovf_nxt = 1'b1;
      end else if (stat.sl_empty) begin
        sl_we       = 1'b1;
        sl_waddr    = s_head_r;
        s_count_nxt = s_count_r + 1'b1;
      end else begin
        wr_ptr_nxt = s_tail;
      end
    end

    // Insertion walks back from the tail, moving later deadlines up one slot.
    if (cmd.ins_shift) begin
      sl_we = 1'b1;
      if (stat.shift_gt) begin
        sl_wdata   = sl_rdata_r;
        wr_ptr_nxt = s_prev(wr_ptr_r);
      end else begin
        s_count_nxt = s_count_r + 1'b1;
      end
    end

    if (cmd.ins_place) begin
      sl_we       = 1'b1;
      s_count_nxt = s_count_r + 1'b1;
    end

    if (cmd.tick_init) begin
      now_nxt = now_r + swrq_tick_t'(1);
    end

    if (cmd.wake_step && stat.wake_now) begin
      s_head_nxt  = s_next(s_head_r);
      s_count_nxt = s_count_r - 1'b1;
      if (r_count_r != R_FULL) begin
        rq_we       = 1'b1;
        rq_wdata    = sl_rdata_r.id;
        r_tail_nxt  = r_next(r_tail_r);
        r_count_nxt = r_count_r + 1'b1;
        wcnt_nxt    = (wcnt_r == WOKE_MAX) ? WOKE_MAX : wcnt_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end

    if (cmd.push) begin
      if (r_count_r != R_FULL) begin
        rq_we       = 1'b1;
        r_tail_nxt  = r_next(r_tail_r);
        r_count_nxt = r_count_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end

    // The head entry is read on the pop edge and captured in the following cycle.
    if (cmd.pop && (r_count_r != '0)) begin
      pvalid_nxt  = 1'b1;
      r_head_nxt  = r_next(r_head_r);
      r_count_nxt = r_count_r - 1'b1;
    end

    if (cmd.pop_rd && pvalid_r) begin
      picked_nxt = rq_rdata_r;
    end

    if (cmd.tick_init || cmd.wake_step) begin
      sl_raddr = s_head_nxt;
    end else begin
      sl_raddr = s_prev(wr_ptr_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_head_r  <= '0;
      s_count_r <= '0;
      wr_ptr_r  <= '0;
      now_r     <= '0;
      r_head_r  <= '0;
      r_tail_r  <= '0;
      r_count_r <= '0;
    end else begin
      s_head_r  <= s_head_nxt;
      s_count_r <= s_count_nxt;
      wr_ptr_r  <= wr_ptr_nxt;
      now_r     <= now_nxt;
      r_head_r  <= r_head_nxt;
      r_tail_r  <= r_tail_nxt;
      r_count_r <= r_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r     <= id_nxt;
    ticks_r  <= ticks_nxt;
    picked_r <= picked_nxt;
    pvalid_r <= pvalid_nxt;
    wcnt_r   <= wcnt_nxt;
    ovf_r    <= ovf_nxt;
    if (cmd.out_load) begin
      out_picked_r <= picked_r;
      out_pvalid_r <= pvalid_r;
      out_wany_r   <= (wcnt_r != '0);
      out_wcnt_r   <= wcnt_r;
      out_ovf_r    <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (sl_we) begin
      sl_mem[sl_waddr] <= sl_wdata;
    end
    sl_rdata_r <= sl_mem[sl_raddr];
  end

  always_ff @(posedge clk) begin
    if (rq_we) begin
      rq_mem[rq_waddr] <= rq_wdata;
    end
    rq_rdata_r <= rq_mem[r_head_r];
  end

  assign out_picked_thread = out_picked_r;
  assign out_picked_valid  = out_pvalid_r;
  assign out_woke_any      = out_wany_r;
  assign out_woke_count    = out_wcnt_r;
  assign out_overflow      = out_ovf_r;

endmodule

/* rtl/swrq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sleep/wakeup ready queue controller
// Sequences one transaction at a time and owns the result valid flag.
// ----------------------------------------------------------------------------
module swrq_ctrl import swrq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_opcode,
  output logic       out_valid,
  input  logic       out_ready,
  input  swrq_stat_t stat,
  output swrq_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_INIT,
    ST_INS_SHIFT,
    ST_INS_PLACE,
    ST_TICK_INIT,
    ST_WAKE,
    ST_PUSH,
    ST_POP,
    ST_POP_RD,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (swrq_op_t'(in_opcode))
            OP_SLEEP: state_nxt = ST_INS_INIT;
            OP_TICK:  state_nxt = ST_TICK_INIT;
            OP_READY: state_nxt = ST_PUSH;
            OP_PICK:  state_nxt = ST_POP;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_INS_INIT: begin
        cmd.ins_init = 1'b1;
        state_nxt    = (stat.sl_full || stat.sl_empty) ? ST_DONE : ST_INS_SHIFT;
      end
      ST_INS_SHIFT: begin
        cmd.ins_shift = 1'b1;
        if (!stat.shift_gt) begin
          state_nxt = ST_DONE;
        end else if (stat.at_head) begin
          state_nxt = ST_INS_PLACE;
        end
      end
      ST_INS_PLACE: begin
        cmd.ins_place = 1'b1;
        state_nxt     = ST_DONE;
      end
      ST_TICK_INIT: begin
        cmd.tick_init = 1'b1;
        state_nxt     = ST_WAKE;
      end
      ST_WAKE: begin
        cmd.wake_step = 1'b1;
        if (!stat.wake_now) begin
          state_nxt = ST_DONE;
        end
      end
      ST_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = ST_POP_RD;
      end
      ST_POP_RD: begin
        cmd.pop_rd = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* rtl/sleep_wakeup_ready_queue_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sleep/wakeup ready queue
// Sorted sleeper table with timed wake-up into a FIFO ready queue.
// ----------------------------------------------------------------------------
// The controller sequences one transaction at a time and accepts the next
// only once it is idle again; the single-port walk over the sleeper ring
// sets how long a sleep or tick takes. A finished result waits in the done
// state while the previous result is still held waiting for out_ready.
// Synchronous reset empties both queues; memory contents are not cleared.
//
// The sleeper table is a ring buffer in a memory. Each entry holds a thread
// id and the absolute tick count at which it wakes, so a tick only advances
// a free-running tick counter instead of decrementing every entry. Remaining
// time is the entry's deadline minus the counter, taken modulo the counter
// width; it is always between one and the largest sleep, so it never wraps
// ambiguously. Entries stay sorted by remaining time.
//
// A sleep transaction walks back from the tail one entry per cycle, moving
// each entry with a later wake time up one slot, then writes the new entry
// after the last one that wakes no later. A tick transaction advances the
// counter and pops front sleepers that have reached zero into the ready
// FIFO, one per cycle. When the FIFO is full the sleeper still leaves the
// table, its id is dropped and the overflow flag is raised.
//
// The controller accepts a new transaction as soon as it is idle, even while
// the previous result still waits in the output register; a finished result
// then waits until that register is free.
module sleep_wakeup_ready_queue_top import swrq_pkg::*; #(
  parameter int SLEEP_SLOTS = SLEEP_SLOTS_DEF,
  parameter int READY_DEPTH = READY_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  swrq_in_if.sink   in_if,
  swrq_out_if.source out_if
);

  swrq_cmd_t  cmd;
  swrq_stat_t stat;

  // Sequencer: one state per step of a transaction.
  swrq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .in_opcode (in_if.opcode),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Storage, pointers and result registers.
  swrq_datapath #(
    .SLEEP_SLOTS (SLEEP_SLOTS),
    .READY_DEPTH (READY_DEPTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_id             (in_if.thread_id),
    .in_ticks          (in_if.sleep_ticks),
    .out_picked_thread (out_if.picked_thread),
    .out_picked_valid  (out_if.picked_valid),
    .out_woke_any      (out_if.woke_any),
    .out_woke_count    (out_if.woke_count),
    .out_overflow      (out_if.overflow)
  );

endmodule

/* dv/swrq_sched_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sleep/wakeup ready queue result checker
// Watches both channels, predicts each result from the accepted transactions
// and compares what the block returns against that prediction, field by field.
// ----------------------------------------------------------------------------
module swrq_sched_checker import swrq_pkg::*; #(
  parameter int SLEEP_SLOTS = SLEEP_SLOTS_DEF,
  parameter int READY_DEPTH = READY_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  swrq_in_if          in_ch,
  swrq_out_if         out_ch,
  output int unsigned mismatches,
  output int unsigned results_waiting
);

  // Sleepers are held by remaining ticks, not by deadline.
  typedef struct packed {
    swrq_id_t   id;
    swrq_tick_t left;
  } sleeper_t;

  typedef struct packed {
    swrq_id_t    picked_thread;
    logic        picked_valid;
    logic        woke_any;
    swrq_count_t woke_count;
    logic        overflow;
  } sched_result_t;

  sleeper_t      sleepers[$];
  swrq_id_t      ready_fifo[$];
  sched_result_t results_owed[$];
  int unsigned   fail_total;

  function automatic sched_result_t sched_step(swrq_op_t op, swrq_id_t id,
                                               swrq_tick_t ticks);
    sched_result_t r;
    sleeper_t      s;
    int unsigned   pos;
    int unsigned   k;
    int unsigned   woken;
    r = '0;
    case (op)
      OP_SLEEP: begin
        if (sleepers.size() >= SLEEP_SLOTS) begin
          r.overflow = 1'b1;
        end else begin
          s.id   = id;
          s.left = (ticks == '0) ? swrq_tick_t'(1) : ticks;
          pos = 0;
          // A new sleeper goes behind every entry due no later than itself.
          while (pos < sleepers.size() && sleepers[pos].left <= s.left) pos++;
          sleepers.insert(pos, s);
        end
      end
      OP_TICK: begin
        for (k = 0; k < sleepers.size(); k++) begin
          if (sleepers[k].left != '0) sleepers[k].left = sleepers[k].left - 1'b1;
        end
        woken = 0;
        while (sleepers.size() > 0 && sleepers[0].left == '0) begin
          s = sleepers.pop_front();
          if (ready_fifo.size() < READY_DEPTH) begin
            ready_fifo.push_back(s.id);
            woken++;
          end else begin
            r.overflow = 1'b1;
          end
        end
        r.woke_any   = (woken != 0);
        r.woke_count = (woken > int'(WOKE_MAX)) ? WOKE_MAX : swrq_count_t'(woken);
      end
      OP_READY: begin
        if (ready_fifo.size() >= READY_DEPTH) r.overflow = 1'b1;
        else ready_fifo.push_back(id);
      end
      default: begin
        if (ready_fifo.size() > 0) begin
          r.picked_thread = ready_fifo.pop_front();
          r.picked_valid  = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fail_total++;
    end
  endtask

  always @(posedge clk) begin
    sched_result_t want;
    sched_result_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.picked_thread = out_ch.picked_thread;
        got.picked_valid  = out_ch.picked_valid;
        got.woke_any      = out_ch.woke_any;
        got.woke_count    = out_ch.woke_count;
        got.overflow      = out_ch.overflow;
        if (results_owed.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, got);
          fail_total++;
        end else begin
          want = results_owed.pop_front();
          check_field("picked_thread", want.picked_thread, got.picked_thread);
          check_field("picked_valid", want.picked_valid, got.picked_valid);
          check_field("woke_any", want.woke_any, got.woke_any);
          check_field("woke_count", want.woke_count, got.woke_count);
          check_field("overflow", want.overflow, got.overflow);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        results_owed.push_back(sched_step(swrq_op_t'(in_ch.opcode), in_ch.thread_id,
                                          in_ch.sleep_ticks));
      end
    end
    mismatches      <= fail_total;
    results_waiting <= results_owed.size();
  end

endmodule

/* dv/sleep_wakeup_ready_queue_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sleep/wakeup ready queue testbench
// Drives directed and phased random scheduler traffic with random stalls on
// both channels; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module sleep_wakeup_ready_queue_top_tb;
  import swrq_pkg::*;

  localparam int SLEEP_SLOTS   = SLEEP_SLOTS_DEF;
  localparam int READY_DEPTH   = READY_DEPTH_DEF;
  localparam int PHASE_ITEMS   = 150;
  localparam int PHASES        = 13;
  // The slowest transaction walks the whole sleeper ring.
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 800_000;

  // Traffic shapes for the random phases. Each one pushes the scheduler
  // toward a different corner: full stores, mass wake-ups, or emptiness.
  typedef enum int unsigned {
    LOAD_UP,
    WAKE_STORM,
    DRAIN,
    MIXED
  } traffic_mode_t;

  logic        clk;
  logic        rst_n;
  bit          send_idle_en;
  bit          sink_idle_en;
  int unsigned mismatches;
  int unsigned results_waiting;
  int unsigned cycles;

  swrq_in_if  in_ch ();
  swrq_out_if out_ch ();

  sleep_wakeup_ready_queue_top #(
    .SLEEP_SLOTS(SLEEP_SLOTS),
    .READY_DEPTH(READY_DEPTH)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  swrq_sched_checker #(
    .SLEEP_SLOTS(SLEEP_SLOTS),
    .READY_DEPTH(READY_DEPTH)
  ) sched_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatches     (mismatches),
    .results_waiting(results_waiting)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Watchdog: a hung handshake must not stall the run forever. The counter
  // starts from the zero that a two-state variable holds at time zero.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Idle lengths: mostly none, now and then a long stretch that can outlast
  // a whole transaction of the block.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic swrq_op_t draw_op(traffic_mode_t mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (mode)
      // Sleeps and appends outpace picks, so both stores run full and
      // ticks wake sleepers into an already full ready queue.
      LOAD_UP:    return r < 35 ? OP_SLEEP : r < 70 ? OP_READY : r < 90 ? OP_TICK : OP_PICK;
      // Many short sleeps and many ticks: several sleepers wake per tick.
      WAKE_STORM: return r < 45 ? OP_SLEEP : r < 85 ? OP_TICK : r < 90 ? OP_READY : OP_PICK;
      // Mostly picks and ticks, so the queues empty out and picks miss.
      DRAIN:      return r < 10 ? OP_SLEEP : r < 20 ? OP_READY : r < 55 ? OP_TICK : OP_PICK;
      default:    return r < 25 ? OP_SLEEP : r < 50 ? OP_READY : r < 75 ? OP_TICK : OP_PICK;
    endcase
  endfunction

  // Sleep lengths are kept short so sleepers really wake within the run.
  // Zero shows up regularly; the full range only rarely, because such a
  // sleeper occupies its slot for the rest of the test.
  function automatic swrq_tick_t draw_ticks();
    int unsigned r;
    r = $urandom_range(0, 511);
    if (r < 40) return '0;
    if (r < 470) return swrq_tick_t'($urandom_range(1, 6));
    if (r < 510) return swrq_tick_t'($urandom_range(7, 300));
    return swrq_tick_t'($urandom_range(0, 65535));
  endfunction

  // Presents one transaction and returns once it has been accepted. Valid
  // stays high after the handshake so that back-to-back transactions are
  // possible; it drops only for an idle gap or a wait for results.
  task automatic send_txn(swrq_op_t op, swrq_id_t id, swrq_tick_t ticks);
    int unsigned gap;
    gap = send_idle_en ? idle_len() : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.thread_id   <= id;
    in_ch.sleep_ticks <= ticks;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Holds the sender off until every predicted result has come back. The
  // first edge lets the count take in the transaction accepted just now.
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_waiting != 0) @(posedge clk);
  endtask

  // Result side: ready is held low for random stretches when stalling is
  // enabled, independent of whether a result is actually on offer.
  initial begin : result_sink
    int unsigned stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        stall = sink_idle_en ? idle_len() : 0;
      end
    end
  end

  initial begin : stimulus
    int unsigned   phase;
    int unsigned   n;
    swrq_op_t      op;
    traffic_mode_t mode;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.opcode       <= OP_SLEEP;
    in_ch.thread_id    <= '0;
    in_ch.sleep_ticks  <= '0;
    send_idle_en       = 1'b1;
    sink_idle_en       = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. A pick and a tick on the empty block come first, then
    // the id extremes pass through the ready queue.
    send_txn(OP_PICK, 8'h00, '0);
    send_txn(OP_TICK, 8'h00, '0);
    send_txn(OP_READY, 8'hFF, '0);
    send_txn(OP_READY, 8'h00, '1);
    send_txn(OP_PICK, 8'h00, '0);
    // A zero sleep is repaired to one tick, so the sleeper with one tick
    // queues behind it. The longest sleep never wakes during the run. Two
    // equal sleeps must wake in the order they arrived.
    send_txn(OP_SLEEP, 8'hAA, '0);
    send_txn(OP_SLEEP, 8'h55, '1);
    send_txn(OP_SLEEP, 8'h01, 16'd1);
    send_txn(OP_SLEEP, 8'h80, 16'd2);
    send_txn(OP_SLEEP, 8'h5A, 16'd3);
    send_txn(OP_SLEEP, 8'h5B, 16'd3);
    send_txn(OP_TICK, 8'h00, '0);
    send_txn(OP_TICK, 8'h00, '0);
    send_txn(OP_TICK, 8'h00, '0);
    // Drain the ready queue and run one pick past its end.
    repeat (7) send_txn(OP_PICK, 8'h00, '0);
    wait_for_results();

    // Random part: fixed rotation of traffic shapes with random content,
    // random idling per phase, and periodic full drains of the block.
    for (phase = 0; phase < PHASES; phase++) begin
      mode         = traffic_mode_t'(phase % 4);
      send_idle_en = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        op = draw_op(mode);
        send_txn(op, swrq_id_t'($urandom_range(0, 255)),
                 (op == OP_SLEEP) ? draw_ticks() : swrq_tick_t'($urandom));
      end
      if (phase % 3 == 2) wait_for_results();
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_waiting == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sleep_wakeup_ready_queue_top.f */
rtl/swrq_pkg.sv
rtl/swrq_if.sv
rtl/swrq_datapath.sv
rtl/swrq_ctrl.sv
rtl/sleep_wakeup_ready_queue_top.sv
dv/swrq_sched_checker.sv
dv/sleep_wakeup_ready_queue_top_tb.sv
